// ===== rtl/radio_note_selector_with_presets_macros.svh =====
// assertion macros for the radio note selector
// no dependencies; included by the top level
`ifndef RADIO_NOTE_SELECTOR_WITH_PRESETS_MACROS_SVH
`define RADIO_NOTE_SELECTOR_WITH_PRESETS_MACROS_SVH

`ifndef ASSERT_OFF

// property holds at every edge out of reset
`define RNSP_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define RNSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define RNSP_ASSERT(lbl, clk, rst_n, prop, msg)
`define RNSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== rtl/rnsp_pkg.sv =====
// shared types and constants of the radio note selector
// no dependencies
package rnsp_pkg;

	localparam int NUM_NOTES_DEF   = 12;
	localparam int NUM_PRESETS_DEF = 16;
	localparam int BUTTON_W        = 12;
	localparam int NOTE_W          = 4;
	localparam int SLOT_IN_W       = 4;
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = 4;

	// register indexes of the config port
	localparam logic [CFG_IDX_W-1:0] CFG_START_NOTE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_PATCHED  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LOAD_PATCHED   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SAVE_PATCHED   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_PRESET_PATCHED = 3'd4;

	// bit positions in the trigger vector
	localparam int TRG_CLEAR_ALL = 0;
	localparam int TRG_CLEAR     = 1;
	localparam int TRG_SAVE      = 2;
	localparam int TRG_LOAD      = 3;
	localparam int TRG_CLOCK     = 4;
	localparam int TRG_W         = 5;

	typedef struct packed {
		logic [NOTE_W-1:0] start_note;
		logic              clock_patched;
		logic              load_patched;
		logic              save_patched;
		logic              preset_patched;
	} cfg_t;

	typedef struct packed {
		logic [BUTTON_W-1:0]  button_levels;
		logic                 panel_selected;
		logic                 clock_level;
		logic                 clear_level;
		logic                 clear_all_level;
		logic                 save_level;
		logic                 load_level;
		logic [SLOT_IN_W-1:0] save_slot;
		logic [SLOT_IN_W-1:0] load_slot;
		logic [SLOT_IN_W-1:0] preset_slot;
	} item_t;

	typedef struct packed {
		logic [NOTE_W-1:0]   note;
		logic                gate;
		logic [BUTTON_W-1:0] led_mask;
		logic                led_update;
	} result_t;

	// preset store control: fill all, then one write
	typedef struct packed {
		logic              fill;
		logic [NOTE_W-1:0] fill_value;
		logic              wen;
		logic [NOTE_W-1:0] wdata;
	} store_ctl_t;

endpackage

// ===== rtl/radio_note_selector_with_presets.sv =====
// top level of the radio note selector with preset slots
// depends on rnsp_pkg, rnsp_step and the assertion macro header
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------------------
//  in      | sink      | in_valid/in_stall  | button_levels .. preset_slot, one tick
//  out     | source    | out_valid/out_stall| note, gate, led_mask, led_update
//  cfg     | sink      | cfg_we             | cfg_index, cfg_data
//
// an input beat lands in the input register; when the step fires, the step logic
// updates the state and fills the result register; one beat per cycle sustained,
// limited only by the result register drain
// reset clears config, the pipeline valids and the note state; the first
// beat after reset runs init and fills the preset store in that same cycle
// a stalled result holds the input register, a further beat then stalls
`include "radio_note_selector_with_presets_macros.svh"

module radio_note_selector_with_presets #(
	parameter int NUM_NOTES   = rnsp_pkg::NUM_NOTES_DEF,
	parameter int NUM_PRESETS = rnsp_pkg::NUM_PRESETS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// input channel
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [rnsp_pkg::BUTTON_W-1:0]     button_levels,
	input  logic                              panel_selected,
	input  logic                              clock_level,
	input  logic                              clear_level,
	input  logic                              clear_all_level,
	input  logic                              save_level,
	input  logic                              load_level,
	input  logic [rnsp_pkg::SLOT_IN_W-1:0]    save_slot,
	input  logic [rnsp_pkg::SLOT_IN_W-1:0]    load_slot,
	input  logic [rnsp_pkg::SLOT_IN_W-1:0]    preset_slot,
	// result channel
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [rnsp_pkg::NOTE_W-1:0]       note,
	output logic                              gate,
	output logic [rnsp_pkg::BUTTON_W-1:0]     led_mask,
	output logic                              led_update,
	// config write port
	input  logic                              cfg_we,
	input  logic [rnsp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rnsp_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam logic [rnsp_pkg::NOTE_W-1:0] NOTE_MAX = rnsp_pkg::NOTE_W'(NUM_NOTES - 1);

	rnsp_pkg::cfg_t    cfg_q;
	rnsp_pkg::item_t   item_s1;
	logic              valid_s1;
	rnsp_pkg::result_t result_d, result_q;
	logic              out_valid_q;
	logic              advance;
	logic              in_accept;

	// config registers, to be written only while idle; the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rnsp_pkg::CFG_START_NOTE:     cfg_q.start_note     <= cfg_data;
				rnsp_pkg::CFG_CLOCK_PATCHED:  cfg_q.clock_patched  <= cfg_data[0];
				rnsp_pkg::CFG_LOAD_PATCHED:   cfg_q.load_patched   <= cfg_data[0];
				rnsp_pkg::CFG_SAVE_PATCHED:   cfg_q.save_patched   <= cfg_data[0];
				rnsp_pkg::CFG_PRESET_PATCHED: cfg_q.preset_patched <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// the step fires when the input register holds a beat and the result register is free or draining this cycle
	assign advance   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign in_accept = in_valid && !in_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			item_s1.button_levels   <= button_levels;
			item_s1.panel_selected  <= panel_selected;
			item_s1.clock_level     <= clock_level;
			item_s1.clear_level     <= clear_level;
			item_s1.clear_all_level <= clear_all_level;
			item_s1.save_level      <= save_level;
			item_s1.load_level      <= load_level;
			item_s1.save_slot       <= save_slot;
			item_s1.load_slot       <= load_slot;
			item_s1.preset_slot     <= preset_slot;
		end
	end

	// note state, trigger edges and preset store
	rnsp_step #(
		.NUM_NOTES   (NUM_NOTES),
		.NUM_PRESETS (NUM_PRESETS)
	) u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.item   (item_s1),
		.cfg    (cfg_q),
		.result (result_d)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign note       = result_q.note;
	assign gate       = result_q.gate;
	assign led_mask   = result_q.led_mask;
	assign led_update = result_q.led_update;

	// a stall toward the source only while a beat sits in the input register
	`RNSP_ASSERT(a_stall_needs_beat, clk, arst_n, !in_stall || valid_s1, "stall with empty input register")
	// every step firing produces a result beat
	`RNSP_ASSERT_NEXT(a_step_to_result, clk, arst_n, advance, out_valid, "step fired without a result")
	// latched note stays inside the note range
	`RNSP_ASSERT(a_note_range, clk, arst_n, !out_valid || note <= NOTE_MAX, "note out of range")
	// unselected panel shows no leds and no gate
	`RNSP_ASSERT(a_unselected_dark, clk, arst_n,
		!out_valid || led_update || (led_mask == '0 && !gate), "leds or gate while unselected")

endmodule

// ===== rtl/rnsp_preset_store.sv =====
// preset slot store: flop array with fill-all, one write and one forwarded read
// depends on rnsp_pkg
module rnsp_preset_store #(
	parameter int NUM_PRESETS = rnsp_pkg::NUM_PRESETS_DEF,
	parameter int SLOT_W      = (NUM_PRESETS > 1) ? $clog2(NUM_PRESETS) : 1
) (
	input  logic                      clk,
	input  rnsp_pkg::store_ctl_t      ctl,
	input  logic [SLOT_W-1:0]         waddr,
	input  logic [SLOT_W-1:0]         raddr,
	output logic [rnsp_pkg::NOTE_W-1:0] rd_data
);

	logic [rnsp_pkg::NOTE_W-1:0] mem_q [NUM_PRESETS];

	always_ff @(posedge clk) begin
		for (int p = 0; p < NUM_PRESETS; p++) begin
			if (ctl.wen && waddr == SLOT_W'(p)) begin
				mem_q[p] <= ctl.wdata;
			end else if (ctl.fill) begin
				mem_q[p] <= ctl.fill_value;
			end
		end
	end

	// read sees this beat's fill and write
	always_comb begin
		if (ctl.wen && waddr == raddr) begin
			rd_data = ctl.wdata;
		end else if (ctl.fill) begin
			rd_data = ctl.fill_value;
		end else begin
			rd_data = mem_q[raddr];
		end
	end

endmodule

// ===== rtl/rnsp_step.sv =====
// per-beat note selection logic and its state registers
// depends on rnsp_pkg and rnsp_preset_store
module rnsp_step #(
	parameter int NUM_NOTES   = rnsp_pkg::NUM_NOTES_DEF,
	parameter int NUM_PRESETS = rnsp_pkg::NUM_PRESETS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  rnsp_pkg::item_t   item,
	input  rnsp_pkg::cfg_t    cfg,
	output rnsp_pkg::result_t result
);

	localparam int SLOT_W = (NUM_PRESETS > 1) ? $clog2(NUM_PRESETS) : 1;
	localparam int BTN_N  = (NUM_NOTES < rnsp_pkg::BUTTON_W) ? NUM_NOTES : rnsp_pkg::BUTTON_W;
	localparam logic [SLOT_W-1:0]           SLOT_MAX = SLOT_W'(NUM_PRESETS - 1);
	localparam logic [rnsp_pkg::NOTE_W-1:0] NOTE_MAX = rnsp_pkg::NOTE_W'(NUM_NOTES - 1);

	typedef logic [rnsp_pkg::NOTE_W-1:0] note_t;

	function automatic logic [SLOT_W-1:0] clamp_slot(input logic [rnsp_pkg::SLOT_IN_W-1:0] v);
		if (int'(v) > NUM_PRESETS - 1) begin
			return SLOT_MAX;
		end
		return SLOT_W'(v);
	endfunction

	function automatic note_t clamp_note(input note_t v);
		return (v > NOTE_MAX) ? NOTE_MAX : v;
	endfunction

	note_t                       cur_note_q, pend_note_q;
	logic                        pend_valid_q;
	logic [SLOT_W-1:0]           slot_q;
	logic [BTN_N-1:0]            btn_prev_q;
	logic [rnsp_pkg::TRG_W-1:0]  trig_prev_q;
	logic                        init_q;

	note_t                       seed, cur1, rd_data, rd_note, cur_d, pend_d, pressed;
	logic                        pv1, pv_d, found, immediate, imm_chg, save_eff, load_eff, clr_w;
	logic [SLOT_W-1:0]           preset_in, slot0, slot_d, s_save, s_load, waddr, raddr;
	logic [rnsp_pkg::TRG_W-1:0]  trig, rise_t;
	logic [BTN_N-1:0]            btn, rise_b;
	rnsp_pkg::store_ctl_t        ctl;

	assign trig = {item.clock_level, item.load_level, item.save_level,
	               item.clear_level, item.clear_all_level};
	assign rise_t = trig & ~trig_prev_q;
	assign btn = item.button_levels[BTN_N-1:0];
	assign rise_b = btn & ~btn_prev_q;

	// init, clears and store addressing
	always_comb begin
		seed      = clamp_note(cfg.start_note);
		preset_in = clamp_slot(item.preset_slot);
		immediate = cfg.preset_patched && !cfg.load_patched && !cfg.save_patched;
		cur1      = init_q ? cur_note_q : seed;
		pv1       = init_q ? pend_valid_q : 1'b0;
		slot0     = init_q ? slot_q : preset_in;
		ctl.fill  = !init_q;
		clr_w     = 1'b0;
		if (rise_t[rnsp_pkg::TRG_CLEAR_ALL]) begin
			cur1     = seed;
			pv1      = 1'b0;
			ctl.fill = 1'b1;
		end else if (rise_t[rnsp_pkg::TRG_CLEAR]) begin
			cur1  = seed;
			pv1   = 1'b0;
			clr_w = immediate;
		end
		save_eff = cfg.save_patched && rise_t[rnsp_pkg::TRG_SAVE];
		load_eff = cfg.load_patched && rise_t[rnsp_pkg::TRG_LOAD];
		s_save   = cfg.preset_patched ? preset_in : clamp_slot(item.save_slot);
		s_load   = cfg.preset_patched ? preset_in : clamp_slot(item.load_slot);
		imm_chg  = immediate && (preset_in != slot0);
		// clear, save and slot change all store the post-clear note
		ctl.fill_value = seed;
		ctl.wdata      = cur1;
		ctl.wen        = en && (clr_w || save_eff || imm_chg);
		ctl.fill       = en && ctl.fill;
		waddr          = save_eff ? s_save : slot0;
		raddr          = immediate ? preset_in : s_load;
	end

	rnsp_preset_store #(
		.NUM_PRESETS (NUM_PRESETS),
		.SLOT_W      (SLOT_W)
	) u_store (
		.clk     (clk),
		.ctl     (ctl),
		.waddr   (waddr),
		.raddr   (raddr),
		.rd_data (rd_data)
	);

	// load, slot change, buttons and clock
	always_comb begin
		rd_note = clamp_note(rd_data);
		cur_d   = cur1;
		pv_d    = pv1;
		pend_d  = pend_note_q;
		slot_d  = slot0;
		if (load_eff) begin
			cur_d = rd_note;
		end
		if (imm_chg) begin
			cur_d  = rd_note;
			slot_d = preset_in;
		end
		found   = 1'b0;
		pressed = '0;
		for (int i = 0; i < BTN_N; i++) begin
			if (rise_b[i]) begin
				found   = 1'b1;
				pressed = rnsp_pkg::NOTE_W'(i);
			end
		end
		if (item.panel_selected && found) begin
			if (cfg.clock_patched) begin
				pend_d = pressed;
				pv_d   = 1'b1;
			end else begin
				cur_d = pressed;
			end
		end
		if (cfg.clock_patched && rise_t[rnsp_pkg::TRG_CLOCK] && pv_d) begin
			cur_d = pend_d;
			pv_d  = 1'b0;
		end
		cur_d = clamp_note(cur_d);

		result.note       = cur_d;
		result.gate       = item.panel_selected && (btn != '0);
		result.led_update = item.panel_selected;
		for (int i = 0; i < rnsp_pkg::BUTTON_W; i++) begin
			result.led_mask[i] = item.panel_selected && (cur_d == rnsp_pkg::NOTE_W'(i));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_note_q   <= '0;
			pend_note_q  <= '0;
			pend_valid_q <= 1'b0;
			slot_q       <= '0;
			btn_prev_q   <= '0;
			trig_prev_q  <= '0;
			init_q       <= 1'b0;
		end else if (en) begin
			cur_note_q   <= cur_d;
			pend_note_q  <= pend_d;
			pend_valid_q <= pv_d;
			slot_q       <= slot_d;
			btn_prev_q   <= btn;
			trig_prev_q  <= trig;
			init_q       <= 1'b1;
		end
	end

endmodule
